/* src/gad_pkg.sv */
//------------------------------------------------------------------------------
// gad_pkg
// shared types, constants and the cordic arctangent table
//------------------------------------------------------------------------------
`default_nettype none
package gad_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam int ITER_W = $clog2(CORDIC_ITERS + 1);
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_POSE   = 2'd0,
		OP_START  = 2'd1,
		OP_TICK   = 2'd2,
		OP_CANCEL = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE       = 3'd0,
		ST_OUTSIDE    = 3'd1,
		ST_CONFIRMING = 3'd2,
		ST_SUCCEEDED  = 3'd3,
		ST_CANCELED   = 3'd4,
		ST_REJECTED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_GOAL_X  = 3'd0,
		REG_GOAL_Y  = 3'd1,
		REG_GOAL_Z  = 3'd2,
		REG_GOAL_HD = 3'd3,
		REG_RADIUS  = 3'd4,
		REG_HEIGHT  = 3'd5,
		REG_HDLIM   = 3'd6,
		REG_DWELL   = 3'd7
	} reg_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic [31:0]        now_ms;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [24:0] distance_mm;
		logic [31:0] elapsed_ms;
		logic        inside_res;
	} out_word_t;

	typedef struct packed {
		logic signed [23:0] goal_x_mm;
		logic signed [23:0] goal_y_mm;
		logic signed [23:0] goal_z_mm;
		logic [15:0]        goal_heading;
		logic [15:0]        radius_limit_mm;
		logic [15:0]        height_limit_mm;
		logic [15:0]        heading_limit;
		logic [15:0]        dwell_ms;
	} cfg_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/gad_stream_if.sv */
//------------------------------------------------------------------------------
// gad_stream_if
// valid/ready channels carrying one word
//------------------------------------------------------------------------------
`default_nettype none
interface gad_in_if import gad_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gad_out_if import gad_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gad_cfg_if ();
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* src/gad_front.sv */
//------------------------------------------------------------------------------
// gad_front
// accepts words, computes pose yaw by iterative cordic, holds a two-entry queue
//------------------------------------------------------------------------------
`default_nettype none
module gad_front import gad_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	gad_in_if.sink        in_ch,
	output in_word_t      q_word,
	output logic [15:0]   q_yaw,
	output logic          q_valid,
	input  wire logic     q_pop
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_PREP = 3'b010,
		F_ITER = 3'b100
	} fstate_t;

	fstate_t            state_q;
	in_word_t           word_q;
	logic signed [35:0] s_q, c_q;
	logic [31:0]        ang_q;
	logic [ITER_W-1:0]  it_q;
	logic signed [31:0] pwz_q, pxy_q, pyy_q, pzz_q;

	in_word_t    qw_q [QDEPTH];
	logic [15:0] qy_q [QDEPTH];
	logic        qrd_q, qwr_q;
	logic [1:0]  cnt_q;

	logic        push;
	logic [15:0] push_yaw;
	logic signed [35:0] s0, c0, ds, dc;

	assign in_ch.ready = (state_q == F_IDLE) && (cnt_q < 2'(QDEPTH));

	always_comb begin
		s0 = 36'(pwz_q + pxy_q) <<< 1;
		c0 = (36'sd1 <<< 30) - (36'(pyy_q + pzz_q) <<< 1);
		ds = s_q >>> it_q;
		dc = c_q >>> it_q;
	end

	always_comb begin
		push     = 1'b0;
		push_yaw = 16'd0;
		case (state_q)
			F_IDLE: begin
				if (in_ch.valid && in_ch.ready && in_ch.data.operation != OP_POSE) begin
					push = 1'b1;
				end
			end
			F_PREP: begin
				if (s0 == 36'sd0 && c0 == 36'sd0) begin
					push = 1'b1;
				end
			end
			F_ITER: begin
				if (it_q == ITER_W'(CORDIC_ITERS)) begin
					push     = 1'b1;
					push_yaw = 16'((ang_q + 32'h8000) >> 16);
				end
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (in_ch.valid && in_ch.ready && in_ch.data.operation == OP_POSE)
					state_q <= F_PREP;
				F_PREP: state_q <= (s0 == 36'sd0 && c0 == 36'sd0) ? F_IDLE : F_ITER;
				F_ITER: if (it_q == ITER_W'(CORDIC_ITERS)) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				word_q <= in_ch.data;
				pwz_q  <= in_ch.data.quat_w * in_ch.data.quat_z;
				pxy_q  <= in_ch.data.quat_x * in_ch.data.quat_y;
				pyy_q  <= in_ch.data.quat_y * in_ch.data.quat_y;
				pzz_q  <= in_ch.data.quat_z * in_ch.data.quat_z;
			end
			F_PREP: begin
				it_q <= '0;
				if (c0 < 0) begin
					c_q   <= -c0;
					s_q   <= -s0;
					ang_q <= 32'h8000_0000;
				end else begin
					c_q   <= c0;
					s_q   <= s0;
					ang_q <= 32'd0;
				end
			end
			F_ITER: begin
				if (it_q != ITER_W'(CORDIC_ITERS)) begin
					it_q <= it_q + 1'b1;
					if (s_q >= 0) begin
						c_q   <= c_q + ds;
						s_q   <= s_q - dc;
						ang_q <= ang_q + atan_entry(5'(it_q));
					end else begin
						c_q   <= c_q - ds;
						s_q   <= s_q + dc;
						ang_q <= ang_q - atan_entry(5'(it_q));
					end
				end
			end
			default: it_q <= it_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qrd_q <= 1'b0;
			qwr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) qwr_q <= ~qwr_q;
			if (q_pop) qrd_q <= ~qrd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qw_q[qwr_q] <= (state_q == F_IDLE) ? in_ch.data : word_q;
			qy_q[qwr_q] <= push_yaw;
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_word  = qw_q[qrd_q];
	assign q_yaw   = qy_q[qrd_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue underflow");
	a_prep_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_PREP |=> state_q == F_ITER || state_q == F_IDLE)
		else $error("cordic sequence broken");

endmodule
`default_nettype wire

/* src/gad_back.sv */
//------------------------------------------------------------------------------
// gad_back
// executes queued words: pose store, goal control, tick evaluation, sqrt
//------------------------------------------------------------------------------
`default_nettype none
module gad_back import gad_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire in_word_t q_word,
	input  wire logic [15:0] q_yaw,
	input  wire logic   q_valid,
	output logic        q_pop,
	gad_out_if.source   out_ch
);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_DIFF = 5'b00010,
		B_SQ   = 5'b00100,
		B_SUM  = 5'b01000,
		B_ROOT = 5'b10000
	} bstate_t;

	bstate_t            state_q;
	logic signed [23:0] cur_x_q, cur_y_q, cur_z_q;
	logic [15:0]        cur_heading_q;
	logic               pose_seen_q, goal_active_q, in_area_q;
	logic [31:0]        start_time_q, entered_time_q;
	logic [31:0]        now_q;

	logic signed [24:0] dx_q, dy_q, dz_q;
	logic [15:0]        ayaw_q;
	logic [49:0]        sx_q, sy_q, sz_q;
	logic [31:0]        rr_q;
	logic [50:0]        hxy_q;
	logic [51:0]        v_q;
	logic [51:0]        r_q;
	logic [51:0]        bit_q;
	logic               ok_q;

	logic        out_full_q;
	out_word_t   out_q;
	logic        out_free;
	logic [15:0] dyaw;
	logic [24:0] adz;
	logic [51:0] rb;

	assign out_free     = !out_full_q || out_ch.ready;
	assign out_ch.valid = out_full_q;
	assign out_ch.data  = out_q;
	assign dyaw = cur_heading_q - cfg.goal_heading;
	assign adz  = dz_q[24] ? 25'(-dz_q) : 25'(dz_q);
	assign rb   = r_q + bit_q;

	always_comb begin
		q_pop = 1'b0;
		if (state_q == B_IDLE && q_valid && out_free) begin
			q_pop = (q_word.operation != OP_TICK) || !goal_active_q;
		end
		if (state_q == B_DIFF) q_pop = 1'b0;
		if (state_q == B_ROOT && bit_q == 52'd0 && out_free) q_pop = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			cur_z_q        <= '0;
			cur_heading_q  <= '0;
			pose_seen_q    <= 1'b0;
			goal_active_q  <= 1'b0;
			in_area_q      <= 1'b0;
			start_time_q   <= '0;
			entered_time_q <= '0;
			out_full_q     <= 1'b0;
		end else begin
			// a popped word always loads the result register
			out_full_q <= q_pop || (out_full_q && !out_ch.ready);
			case (state_q)
				B_IDLE: begin
					if (q_valid && out_free) begin
						if (q_word.operation == OP_TICK && goal_active_q) begin
							state_q <= B_DIFF;
						end else begin
							case (q_word.operation)
								OP_POSE: begin
									cur_x_q       <= q_word.pos_x;
									cur_y_q       <= q_word.pos_y;
									cur_z_q       <= q_word.pos_z;
									cur_heading_q <= q_yaw;
									pose_seen_q   <= 1'b1;
								end
								OP_START: begin
									if (pose_seen_q) begin
										goal_active_q <= 1'b1;
										in_area_q     <= 1'b0;
										start_time_q  <= q_word.now_ms;
									end
								end
								OP_CANCEL: begin
									goal_active_q <= 1'b0;
									in_area_q     <= 1'b0;
								end
								default: pose_seen_q <= pose_seen_q;
							endcase
						end
					end
				end
				B_DIFF: state_q <= B_SQ;
				B_SQ:   state_q <= B_SUM;
				B_SUM:  state_q <= B_ROOT;
				B_ROOT: begin
					if (bit_q == 52'd0 && out_free) begin
						state_q <= B_IDLE;
						if (ok_q && !in_area_q) begin
							in_area_q      <= 1'b1;
							entered_time_q <= now_q;
						end else if (ok_q) begin
							if ((now_q - entered_time_q) >= 32'(cfg.dwell_ms)) begin
								goal_active_q <= 1'b0;
								in_area_q     <= 1'b0;
							end
						end else begin
							in_area_q <= 1'b0;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				now_q <= q_word.now_ms;
				dx_q  <= 25'(cur_x_q) - 25'(cfg.goal_x_mm);
				dy_q  <= 25'(cur_y_q) - 25'(cfg.goal_y_mm);
				dz_q  <= 25'(cur_z_q) - 25'(cfg.goal_z_mm);
				if (out_free && q_valid) begin
					out_q.distance_mm <= '0;
					out_q.elapsed_ms  <= '0;
					out_q.inside_res  <= 1'b0;
					case (q_word.operation)
						OP_POSE: out_q.status <= !goal_active_q ? ST_IDLE :
							(in_area_q ? ST_CONFIRMING : ST_OUTSIDE);
						OP_START: out_q.status <= pose_seen_q ? ST_OUTSIDE : ST_REJECTED;
						OP_CANCEL: out_q.status <= goal_active_q ? ST_CANCELED : ST_IDLE;
						default: out_q.status <= ST_IDLE;
					endcase
				end
			end
			B_DIFF: begin
				sx_q   <= 50'(dx_q * dx_q);
				sy_q   <= 50'(dy_q * dy_q);
				sz_q   <= 50'(adz * adz);
				rr_q   <= cfg.radius_limit_mm * cfg.radius_limit_mm;
				ayaw_q <= dyaw[15] ? 16'(-dyaw) : dyaw;
			end
			B_SQ: begin
				hxy_q <= 51'(sx_q) + 51'(sy_q);
				ok_q  <= (adz <= 25'(cfg.height_limit_mm));
			end
			B_SUM: begin
				v_q   <= 52'(hxy_q) + 52'(sz_q);
				r_q   <= '0;
				bit_q <= 52'd1 << 50;
				ok_q  <= ok_q && (hxy_q <= 51'(rr_q)) && (ayaw_q <= cfg.heading_limit);
			end
			B_ROOT: begin
				if (bit_q != 52'd0) begin
					if (v_q >= rb) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else if (out_free) begin
					out_q.distance_mm <= 25'(r_q);
					out_q.elapsed_ms  <= now_q - start_time_q;
					out_q.inside_res  <= ok_q;
					if (ok_q && in_area_q && (now_q - entered_time_q) >= 32'(cfg.dwell_ms))
						out_q.status <= ST_SUCCEEDED;
					else if (ok_q)
						out_q.status <= ST_CONFIRMING;
					else
						out_q.status <= ST_OUTSIDE;
				end
			end
			default: now_q <= now_q;
		endcase
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_full_q && !out_ch.ready |=> out_full_q) else $error("result lost");
	a_goal_ends: assert property (@(posedge clk) disable iff (!arst_n)
		!goal_active_q |-> !in_area_q || $past(goal_active_q)) else $error("area without goal");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == B_IDLE || state_q == B_ROOT) else $error("bad pop");

endmodule
`default_nettype wire

/* src/goal_arrival_detector_unit.sv */
//------------------------------------------------------------------------------
// goal_arrival_detector_unit
// waypoint arrival detector with dwell
//------------------------------------------------------------------------------
// in_ch carries one operation word: pose update, start, tick or cancel.
// out_ch returns exactly one result word per input word, in order.
// cfg_ch writes the goal and limit registers; write only while idle.
// a pose update runs an iterative cordic in the front, one step per cycle,
// unless its yaw vector is zero; other words go straight into the queue.
// a tick with an active goal passes the back through dispatch, difference,
// square and sum stages, a 26-step square root and the result load, which
// waits for a free result register; other words are answered at dispatch.
// a two-word queue lets the front compute the next yaw while the back works.
// when the receiver stalls the result register holds and the queue fills,
// then in_ch.ready drops. reset clears pose, goal state and the queue and
// loads the register defaults.
//------------------------------------------------------------------------------
`default_nettype none
module goal_arrival_detector_unit import gad_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	gad_in_if.sink   in_ch,
	gad_out_if.source out_ch,
	gad_cfg_if.sink  cfg_ch
);

	cfg_t        cfg_q;
	in_word_t    q_word;
	logic [15:0] q_yaw;
	logic        q_valid, q_pop;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_x_mm       <= '0;
			cfg_q.goal_y_mm       <= '0;
			cfg_q.goal_z_mm       <= '0;
			cfg_q.goal_heading    <= '0;
			cfg_q.radius_limit_mm <= 16'd100;
			cfg_q.height_limit_mm <= 16'd100;
			cfg_q.heading_limit   <= 16'd1043;
			cfg_q.dwell_ms        <= 16'd1000;
		end else if (cfg_ch.valid) begin
			case (reg_t'(cfg_ch.index))
				REG_GOAL_X:  cfg_q.goal_x_mm       <= cfg_ch.wdata;
				REG_GOAL_Y:  cfg_q.goal_y_mm       <= cfg_ch.wdata;
				REG_GOAL_Z:  cfg_q.goal_z_mm       <= cfg_ch.wdata;
				REG_GOAL_HD: cfg_q.goal_heading    <= cfg_ch.wdata[15:0];
				REG_RADIUS:  cfg_q.radius_limit_mm <= cfg_ch.wdata[15:0];
				REG_HEIGHT:  cfg_q.height_limit_mm <= cfg_ch.wdata[15:0];
				REG_HDLIM:   cfg_q.heading_limit   <= cfg_ch.wdata[15:0];
				REG_DWELL:   cfg_q.dwell_ms        <= cfg_ch.wdata[15:0];
				default:     cfg_q.dwell_ms        <= cfg_q.dwell_ms;
			endcase
		end
	end

	gad_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_word  (q_word),
		.q_yaw   (q_yaw),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	gad_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_word  (q_word),
		.q_yaw   (q_yaw),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule
`default_nettype wire
